// ----- hdl/mtsp_pkg.sv -----
// Shared types, constants and saturation helpers for the matmul tile size planner.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
`timescale 1ns / 1ps

package mtsp_pkg;

  // Default width of the M, N and K dimensions
  localparam int unsigned DIM_BITS_DEF = 16;

  // Fixed field widths
  localparam int unsigned WB_BITS     = 6;
  localparam int unsigned OUT_BITS    = 16;
  localparam int unsigned WS_BITS     = 40;
  localparam int unsigned BUDGET_BITS = 32;
  localparam int unsigned STEP_BITS   = 16;
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned APB_AW      = 3;

  // Wide compare domain for saturation (covers 2*K*M at 32-bit dims)
  localparam int unsigned WIDE_BITS = 65;

  // Clamp width for N*K before the weight multiply: 2^43 * 1 >> 3 already saturates
  localparam int unsigned P_BITS = 44;

  localparam logic [WS_BITS-1:0]   WS_MAX       = '1;
  localparam logic [P_BITS-1:0]    P_SAT        = {1'b1, {(P_BITS-1){1'b0}}};
  localparam logic [STEP_BITS-1:0] DEFAULT_STEP = 16'd32;

  // Item queue depth between front and back (power of two)
  localparam int unsigned QDEPTH = 2;

  // Register index, taken from paddr[2]
  localparam logic REG_BUDGET = 1'b0;
  localparam logic REG_STEP   = 1'b1;

  // Queue status seen by the back end
  typedef struct packed {
    logic not_empty;
    logic zero_dim;
  } q_status_t;

  // Working-set unit response
  typedef struct packed {
    logic               done;
    logic [WS_BITS-1:0] ws;
  } ws_rsp_t;

  // Saturate a wide value at 2^40-1
  function automatic logic [WS_BITS-1:0] sat_ws(input logic [WIDE_BITS-1:0] x);
    logic [WS_BITS-1:0] r;
    if (x > WIDE_BITS'(WS_MAX)) begin
      r = WS_MAX;
    end else begin
      r = x[WS_BITS-1:0];
    end
    return r;
  endfunction

  // Clamp N*K so the weight product stays narrow and still saturates
  function automatic logic [P_BITS-1:0] clamp_p(input logic [WIDE_BITS-1:0] x);
    logic [P_BITS-1:0] r;
    if (x >= WIDE_BITS'(P_SAT)) begin
      r = P_SAT;
    end else begin
      r = x[P_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/mtsp_front.sv -----
// Front end: takes shape commands, flags zero dimensions, and queues them.
// Depends on mtsp_pkg.
`timescale 1ns / 1ps

module mtsp_front #(
  parameter int unsigned W = mtsp_pkg::DIM_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [W-1:0]                 dim_m_i,
  input  logic [W-1:0]                 dim_n_i,
  input  logic [W-1:0]                 dim_k_i,
  input  logic [mtsp_pkg::WB_BITS-1:0] weight_width_i,
  input  logic                         pop_i,
  output mtsp_pkg::q_status_t          q_st_o,
  output logic [W-1:0]                 head_m_o,
  output logic [W-1:0]                 head_n_o,
  output logic [W-1:0]                 head_k_o,
  output logic [mtsp_pkg::WB_BITS-1:0] head_wb_o
);

  localparam int unsigned PTR_W = (mtsp_pkg::QDEPTH > 1) ? $clog2(mtsp_pkg::QDEPTH) : 1;
  localparam int unsigned CNT_W = PTR_W + 1;

  logic [W-1:0]                 m_mem    [mtsp_pkg::QDEPTH];
  logic [W-1:0]                 n_mem    [mtsp_pkg::QDEPTH];
  logic [W-1:0]                 k_mem    [mtsp_pkg::QDEPTH];
  logic [mtsp_pkg::WB_BITS-1:0] wb_mem   [mtsp_pkg::QDEPTH];
  logic                         zero_mem [mtsp_pkg::QDEPTH];

  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push;
  logic             zero_dim;

  // Accept while the queue has room
  assign busy_o   = (cnt_q == CNT_W'(mtsp_pkg::QDEPTH));
  assign push     = start_i && !busy_o;
  assign zero_dim = (dim_m_i == '0) || (dim_n_i == '0) || (dim_k_i == '0);

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      m_mem[wr_ptr_q]    <= dim_m_i;
      n_mem[wr_ptr_q]    <= dim_n_i;
      k_mem[wr_ptr_q]    <= dim_k_i;
      wb_mem[wr_ptr_q]   <= weight_width_i;
      zero_mem[wr_ptr_q] <= zero_dim;
    end
  end

  // Head of queue
  assign q_st_o.not_empty = (cnt_q != '0);
  assign q_st_o.zero_dim  = zero_mem[rd_ptr_q];
  assign head_m_o         = m_mem[rd_ptr_q];
  assign head_n_o         = n_mem[rd_ptr_q];
  assign head_k_o         = k_mem[rd_ptr_q];
  assign head_wb_o        = wb_mem[rd_ptr_q];

endmodule

// ----- hdl/mtsp_ws.sv -----
// Working-set evaluator: Mt*K*2 + floor(Nt*K*wbits/8) + Mt*Nt*2, saturated at 2^40-1.
// One shared multiplier walks the three products in turn. Depends on mtsp_pkg.
`timescale 1ns / 1ps

module mtsp_ws #(
  parameter int unsigned W = mtsp_pkg::DIM_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         go_i,
  input  logic [W-1:0]                 mt_i,
  input  logic [W-1:0]                 nt_i,
  input  logic [W-1:0]                 k_i,
  input  logic [mtsp_pkg::WB_BITS-1:0] wbits_i,
  output mtsp_pkg::ws_rsp_t            rsp_o
);

  localparam int unsigned PW  = 2 * W;
  localparam int unsigned BPW = mtsp_pkg::P_BITS + mtsp_pkg::WB_BITS;
  localparam int unsigned SW  = mtsp_pkg::WS_BITS + 2;

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_A    = 6'b000010,
    PH_P    = 6'b000100,
    PH_C    = 6'b001000,
    PH_B    = 6'b010000,
    PH_SUM  = 6'b100000
  } ws_phase_e;

  ws_phase_e phase_q, phase_d;
  logic      done_q, done_d;

  logic [W-1:0]                 op_a, op_b;
  logic [PW-1:0]                prod;
  logic [PW-1:0]                prod_q;
  logic [mtsp_pkg::P_BITS-1:0]  p_q;
  logic [BPW-1:0]               wprod;
  logic [SW-1:0]                sum;
  logic [mtsp_pkg::WS_BITS-1:0] a_q, b_q, c_q, ws_q;

  // Shared multiplier operand select
  always_comb begin
    op_a = mt_i;
    op_b = k_i;
    case (phase_q)
      PH_P: begin
        op_a = nt_i;
        op_b = k_i;
      end
      PH_C: begin
        op_a = mt_i;
        op_b = nt_i;
      end
      default: begin
        op_a = mt_i;
        op_b = k_i;
      end
    endcase
  end

  assign prod  = PW'(op_a) * PW'(op_b);
  assign wprod = BPW'(p_q) * BPW'(wbits_i);
  assign sum   = SW'(a_q) + SW'(b_q) + SW'(c_q);

  // Phase sequencing
  always_comb begin
    phase_d = phase_q;
    done_d  = 1'b0;
    case (phase_q)
      PH_IDLE: if (go_i) begin
        phase_d = PH_A;
      end
      PH_A:    phase_d = PH_P;
      PH_P:    phase_d = PH_C;
      PH_C:    phase_d = PH_B;
      PH_B:    phase_d = PH_SUM;
      PH_SUM: begin
        phase_d = PH_IDLE;
        done_d  = 1'b1;
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  // Product terms, each saturated as it is formed
  always_ff @(posedge clk_i) begin
    case (phase_q)
      PH_A: prod_q <= prod;
      PH_P: begin
        a_q    <= mtsp_pkg::sat_ws(mtsp_pkg::WIDE_BITS'(prod_q) << 1);
        prod_q <= prod;
      end
      PH_C: begin
        p_q    <= mtsp_pkg::clamp_p(mtsp_pkg::WIDE_BITS'(prod_q));
        prod_q <= prod;
      end
      PH_B: begin
        c_q <= mtsp_pkg::sat_ws(mtsp_pkg::WIDE_BITS'(prod_q) << 1);
        b_q <= mtsp_pkg::sat_ws(mtsp_pkg::WIDE_BITS'(wprod >> 3));
      end
      PH_SUM: ws_q <= mtsp_pkg::sat_ws(mtsp_pkg::WIDE_BITS'(sum));
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ws   = ws_q;

endmodule

// ----- hdl/mtsp_div.sv -----
// Restoring divider, one quotient bit per cycle, for the tile counts and edge sizes.
// Depends on mtsp_pkg only for the default width.
`timescale 1ns / 1ps

module mtsp_div #(
  parameter int unsigned W = mtsp_pkg::DIM_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         go_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);

  localparam int unsigned CW = $clog2(W);

  logic          run_q, run_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W:0]    rem_q;
  logic [W-1:0]  quot_q;
  logic [W-1:0]  dvs_q;

  logic [W:0]    rem_sh;
  logic [W:0]    diff;

  // One restoring step
  assign rem_sh = {rem_q[W-1:0], quot_q[W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (go_i) begin
      run_d = 1'b1;
      cnt_d = CW'(W - 1);
    end else if (run_q) begin
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath: dividend shifts out of quot_q as quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      rem_q  <= '0;
      quot_q <= dividend_i;
      dvs_q  <= divisor_i;
    end else if (run_q) begin
      if (!diff[W]) begin
        rem_q  <= diff;
        quot_q <= {quot_q[W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        quot_q <= {quot_q[W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q[W-1:0];

endmodule

// ----- hdl/mtsp_back.sv -----
// Back end: plans one queued shape (width search, height search, counts, final working set).
// Depends on mtsp_pkg, mtsp_ws and mtsp_div.
`timescale 1ns / 1ps

module mtsp_back #(
  parameter int unsigned W = mtsp_pkg::DIM_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mtsp_pkg::q_status_t              q_st_i,
  input  logic [W-1:0]                     head_m_i,
  input  logic [W-1:0]                     head_n_i,
  input  logic [W-1:0]                     head_k_i,
  input  logic [mtsp_pkg::WB_BITS-1:0]     head_wb_i,
  output logic                             pop_o,
  input  logic [mtsp_pkg::BUDGET_BITS-1:0] budget_i,
  input  logic [mtsp_pkg::STEP_BITS-1:0]   step_i,
  output logic                             done_o,
  output logic                             shape_ok_o,
  output logic [mtsp_pkg::OUT_BITS-1:0]    tile_height_o,
  output logic [mtsp_pkg::OUT_BITS-1:0]    tile_width_o,
  output logic [mtsp_pkg::OUT_BITS-1:0]    row_tiles_o,
  output logic [mtsp_pkg::OUT_BITS-1:0]    col_tiles_o,
  output logic [mtsp_pkg::OUT_BITS-1:0]    last_row_height_o,
  output logic [mtsp_pkg::OUT_BITS-1:0]    last_col_width_o,
  output logic [mtsp_pkg::WS_BITS-1:0]     max_working_set_o,
  output logic                             is_tiled_o,
  output logic                             fits_budget_o
);

  localparam int unsigned BI_W  = $clog2(W);
  localparam int unsigned TP_W  = W + mtsp_pkg::STEP_BITS;
  localparam int unsigned CMP_W = 33;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_SETUP = 9'b000000010,
    ST_WS0   = 9'b000000100,
    ST_MUL   = 9'b000001000,
    ST_TRY   = 9'b000010000,
    ST_WST   = 9'b000100000,
    ST_DIVR  = 9'b001000000,
    ST_DIVC  = 9'b010000000,
    ST_FINAL = 9'b100000000
  } back_state_e;

  back_state_e state_q, state_d;
  logic        ws_go_q, ws_go_d;
  logic        div_go_q, div_go_d;
  logic        done_q, done_d;

  // Item and planning registers
  logic [W-1:0]                 m_q, m_d, n_q, n_d, k_q, k_d;
  logic [mtsp_pkg::WB_BITS-1:0] wb_q, wb_d;
  logic [W-1:0]                 mt_q, mt_d, nt_q, nt_d;
  logic [W-1:0]                 start_q, start_d;
  logic [W-1:0]                 vtry_q, vtry_d;
  logic [W-1:0]                 vacc_q, vacc_d;
  logic [W-1:0]                 acc_q, acc_d;
  logic [BI_W-1:0]              bidx_q, bidx_d;
  logic [TP_W-1:0]              tprod_q, tprod_d;
  logic                         hdim_q, hdim_d;
  logic [W-1:0]                 rows_q, rows_d, cols_q, cols_d;
  logic [W-1:0]                 lastr_q, lastr_d, lastc_q, lastc_d;

  // Result registers
  logic                                 shape_ok_q, shape_ok_d;
  logic [mtsp_pkg::OUT_BITS-1:0]        th_q, th_d, tw_q, tw_d;
  logic [mtsp_pkg::OUT_BITS-1:0]        rt_q, rt_d, ct_q, ct_d;
  logic [mtsp_pkg::OUT_BITS-1:0]        lr_q, lr_d, lc_q, lc_d;
  logic [mtsp_pkg::WS_BITS-1:0]         mws_q, mws_d;
  logic                                 tiled_q, tiled_d, fits_q, fits_d;

  // Helpers
  logic [mtsp_pkg::STEP_BITS-1:0] step_eff;
  logic [W-1:0]                   t_cand;
  logic                           t_valid;
  logic [W-1:0]                   v_diff;
  logic                           ws_over;
  logic                           adv, fin;
  logic [W-1:0]                   fin_val;

  mtsp_pkg::ws_rsp_t ws_rsp;
  logic [W-1:0]      ws_mt, ws_nt;
  logic              div_done;
  logic [W-1:0]      div_q, div_r, div_a, div_b;

  function automatic logic [mtsp_pkg::OUT_BITS-1:0] to_out(input logic [W-1:0] v);
    logic [63:0] x;
    x = 64'(v);
    return x[mtsp_pkg::OUT_BITS-1:0];
  endfunction

  function automatic logic le_step(input logic [W-1:0] v,
                                   input logic [mtsp_pkg::STEP_BITS-1:0] s);
    return CMP_W'(v) <= CMP_W'(s);
  endfunction

  assign step_eff = (step_i == '0) ? mtsp_pkg::DEFAULT_STEP : step_i;

  // Candidate step count: accepted bits so far plus the bit under test
  assign t_cand  = acc_q | (W'(1) << bidx_q);
  assign t_valid = tprod_q < TP_W'(start_q);
  assign v_diff  = start_q - tprod_q[W-1:0];
  assign ws_over = mtsp_pkg::WS_BITS'(budget_i) < ws_rsp.ws;

  // Working-set operands: the dimension under search comes from vtry_q
  assign ws_mt = hdim_q ? vtry_q : mt_q;
  assign ws_nt = hdim_q ? nt_q : vtry_q;

  // Divider operands: rows first, then columns
  assign div_a = (state_q == ST_DIVC) ? n_q : m_q;
  assign div_b = (state_q == ST_DIVC) ? nt_q : mt_q;

  mtsp_ws #(
    .W (W)
  ) u_ws (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (ws_go_q),
    .mt_i    (ws_mt),
    .nt_i    (ws_nt),
    .k_i     (k_q),
    .wbits_i (wb_q),
    .rsp_o   (ws_rsp)
  );

  mtsp_div #(
    .W (W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (div_go_q),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (div_q),
    .rem_o      (div_r)
  );

  // Planning sequencer
  always_comb begin
    state_d    = state_q;
    ws_go_d    = 1'b0;
    div_go_d   = 1'b0;
    done_d     = 1'b0;
    pop_o      = 1'b0;
    m_d        = m_q;
    n_d        = n_q;
    k_d        = k_q;
    wb_d       = wb_q;
    mt_d       = mt_q;
    nt_d       = nt_q;
    start_d    = start_q;
    vtry_d     = vtry_q;
    vacc_d     = vacc_q;
    acc_d      = acc_q;
    bidx_d     = bidx_q;
    tprod_d    = tprod_q;
    hdim_d     = hdim_q;
    rows_d     = rows_q;
    cols_d     = cols_q;
    lastr_d    = lastr_q;
    lastc_d    = lastc_q;
    shape_ok_d = shape_ok_q;
    th_d       = th_q;
    tw_d       = tw_q;
    rt_d       = rt_q;
    ct_d       = ct_q;
    lr_d       = lr_q;
    lc_d       = lc_q;
    mws_d      = mws_q;
    tiled_d    = tiled_q;
    fits_d     = fits_q;
    adv        = 1'b0;
    fin        = 1'b0;
    fin_val    = start_q;

    case (state_q)
      ST_IDLE: begin
        if (q_st_i.not_empty) begin
          pop_o = 1'b1;
          m_d   = head_m_i;
          n_d   = head_n_i;
          k_d   = head_k_i;
          wb_d  = head_wb_i;
          if (q_st_i.zero_dim) begin
            // Degenerate shape: all-zero result right away
            done_d     = 1'b1;
            shape_ok_d = 1'b0;
            th_d       = '0;
            tw_d       = '0;
            rt_d       = '0;
            ct_d       = '0;
            lr_d       = '0;
            lc_d       = '0;
            mws_d      = '0;
            tiled_d    = 1'b0;
            fits_d     = 1'b0;
          end else begin
            mt_d = head_m_i;
            nt_d = head_n_i;
            if (budget_i == '0) begin
              div_go_d = 1'b1;
              state_d  = ST_DIVR;
            end else begin
              hdim_d  = 1'b0;
              start_d = head_n_i;
              state_d = ST_SETUP;
            end
          end
        end
      end

      // Start of one dimension's search
      ST_SETUP: begin
        if (le_step(start_q, step_eff)) begin
          fin     = 1'b1;
          fin_val = start_q;
        end else begin
          vtry_d  = start_q;
          ws_go_d = 1'b1;
          state_d = ST_WS0;
        end
      end

      // Full dimension already fits: keep it; else start the binary search over the step count
      ST_WS0: begin
        if (ws_rsp.done) begin
          if (!ws_over) begin
            fin     = 1'b1;
            fin_val = start_q;
          end else begin
            acc_d   = '0;
            vacc_d  = start_q;
            bidx_d  = BI_W'(W - 1);
            state_d = ST_MUL;
          end
        end
      end

      ST_MUL: begin
        tprod_d = TP_W'(t_cand) * TP_W'(step_eff);
        state_d = ST_TRY;
      end

      // Only candidates still above one step need a working-set check
      ST_TRY: begin
        if (t_valid && !le_step(v_diff, step_eff)) begin
          vtry_d  = v_diff;
          ws_go_d = 1'b1;
          state_d = ST_WST;
        end else begin
          adv = 1'b1;
        end
      end

      // Still over budget: this many steps are not enough, keep the bit
      ST_WST: begin
        if (ws_rsp.done) begin
          if (ws_over) begin
            acc_d  = t_cand;
            vacc_d = vtry_q;
          end
          adv = 1'b1;
        end
      end

      ST_DIVR: begin
        if (div_done) begin
          rows_d   = div_q + W'(div_r != '0);
          lastr_d  = (div_r != '0) ? div_r : mt_q;
          div_go_d = 1'b1;
          state_d  = ST_DIVC;
        end
      end

      ST_DIVC: begin
        if (div_done) begin
          cols_d  = div_q + W'(div_r != '0);
          lastc_d = (div_r != '0) ? div_r : nt_q;
          vtry_d  = mt_q;
          hdim_d  = 1'b1;
          ws_go_d = 1'b1;
          state_d = ST_FINAL;
        end
      end

      // Working set of the full tile, then publish
      ST_FINAL: begin
        if (ws_rsp.done) begin
          done_d     = 1'b1;
          shape_ok_d = 1'b1;
          th_d       = to_out(mt_q);
          tw_d       = to_out(nt_q);
          rt_d       = to_out(rows_q);
          ct_d       = to_out(cols_q);
          lr_d       = to_out(lastr_q);
          lc_d       = to_out(lastc_q);
          mws_d      = ws_rsp.ws;
          tiled_d    = (rows_q > W'(1)) || (cols_q > W'(1));
          fits_d     = (budget_i == '0) || !ws_over;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // Next bit of the step count, or done: one step past the last failing count
    if (adv) begin
      if (bidx_q == '0) begin
        fin     = 1'b1;
        fin_val = vacc_d - W'(step_eff);
      end else begin
        bidx_d  = bidx_q - BI_W'(1);
        state_d = ST_MUL;
      end
    end

    // Dimension settled: width goes on to height, height goes on to the counts
    if (fin) begin
      if (!hdim_q) begin
        nt_d    = fin_val;
        hdim_d  = 1'b1;
        start_d = m_q;
        state_d = ST_SETUP;
      end else begin
        mt_d     = fin_val;
        div_go_d = 1'b1;
        state_d  = ST_DIVR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ws_go_q  <= 1'b0;
      div_go_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      ws_go_q  <= ws_go_d;
      div_go_q <= div_go_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q        <= m_d;
    n_q        <= n_d;
    k_q        <= k_d;
    wb_q       <= wb_d;
    mt_q       <= mt_d;
    nt_q       <= nt_d;
    start_q    <= start_d;
    vtry_q     <= vtry_d;
    vacc_q     <= vacc_d;
    acc_q      <= acc_d;
    bidx_q     <= bidx_d;
    tprod_q    <= tprod_d;
    hdim_q     <= hdim_d;
    rows_q     <= rows_d;
    cols_q     <= cols_d;
    lastr_q    <= lastr_d;
    lastc_q    <= lastc_d;
    shape_ok_q <= shape_ok_d;
    th_q       <= th_d;
    tw_q       <= tw_d;
    rt_q       <= rt_d;
    ct_q       <= ct_d;
    lr_q       <= lr_d;
    lc_q       <= lc_d;
    mws_q      <= mws_d;
    tiled_q    <= tiled_d;
    fits_q     <= fits_d;
  end

  assign done_o            = done_q;
  assign shape_ok_o        = shape_ok_q;
  assign tile_height_o     = th_q;
  assign tile_width_o      = tw_q;
  assign row_tiles_o       = rt_q;
  assign col_tiles_o       = ct_q;
  assign last_row_height_o = lr_q;
  assign last_col_width_o  = lc_q;
  assign max_working_set_o = mws_q;
  assign is_tiled_o        = tiled_q;
  assign fits_budget_o     = fits_q;

endmodule

// ----- hdl/matmul_tile_size_planner_unit.sv -----
// Top level of the matmul tile size planner: config registers, front queue, planning back end.
// Depends on mtsp_pkg, mtsp_front and mtsp_back.
`timescale 1ns / 1ps

// Usage
//   Command: drive dim_m_i, dim_n_i, dim_k_i, weight_width_i with start high; the shape is
//   taken at a clock edge where start is high and busy is low. A two-entry queue sits
//   between the front end and the planner, so two commands can be pending.
//   Result: done_o is high for exactly one cycle with the full plan on the result ports.
//   There is no backpressure; a result must be captured in that cycle.
//   Config: APB write to 0x0 sets budget_bytes, 0x4 sets shrink_step; pready is always
//   high. Write only while no command is pending.
//   Planning: a shape with a zero dimension is answered from the idle state, with no search.
//   With a zero budget: two divider passes plus one working-set pass. With a budget, the
//   binary search over the step count costs one working-set pass through the shared
//   multiplier per bit, for the width and then the height.
//   Commands are planned one at a time; the next leaves the queue once the last is done.
//   Reset: queue empties, planner returns to idle, both registers read zero.

module matmul_tile_size_planner_unit #(
  parameter int unsigned DIM_BITS = mtsp_pkg::DIM_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Command channel
  input  logic                           start,
  output logic                           busy,
  input  logic [DIM_BITS-1:0]            dim_m_i,
  input  logic [DIM_BITS-1:0]            dim_n_i,
  input  logic [DIM_BITS-1:0]            dim_k_i,
  input  logic [mtsp_pkg::WB_BITS-1:0]   weight_width_i,
  // Config port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mtsp_pkg::APB_AW-1:0]    paddr,
  input  logic [mtsp_pkg::APB_DW-1:0]    pwdata,
  output logic [mtsp_pkg::APB_DW-1:0]    prdata,
  output logic                           pready,
  // Result channel
  output logic                           done_o,
  output logic                           shape_ok_o,
  output logic [mtsp_pkg::OUT_BITS-1:0]  tile_height_o,
  output logic [mtsp_pkg::OUT_BITS-1:0]  tile_width_o,
  output logic [mtsp_pkg::OUT_BITS-1:0]  row_tiles_o,
  output logic [mtsp_pkg::OUT_BITS-1:0]  col_tiles_o,
  output logic [mtsp_pkg::OUT_BITS-1:0]  last_row_height_o,
  output logic [mtsp_pkg::OUT_BITS-1:0]  last_col_width_o,
  output logic [mtsp_pkg::WS_BITS-1:0]   max_working_set_o,
  output logic                           is_tiled_o,
  output logic                           fits_budget_o
);

  logic [mtsp_pkg::BUDGET_BITS-1:0] budget_q;
  logic [mtsp_pkg::STEP_BITS-1:0]   step_q;
  logic                             cfg_wr;

  mtsp_pkg::q_status_t          q_st;
  logic                         pop;
  logic [DIM_BITS-1:0]          head_m, head_n, head_k;
  logic [mtsp_pkg::WB_BITS-1:0] head_wb;

  // Config registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= '0;
      step_q   <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == mtsp_pkg::REG_BUDGET) begin
        budget_q <= pwdata;
      end else begin
        step_q <= pwdata[mtsp_pkg::STEP_BITS-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == mtsp_pkg::REG_STEP) ? mtsp_pkg::APB_DW'(step_q) : budget_q;

  mtsp_front #(
    .W (DIM_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .dim_m_i        (dim_m_i),
    .dim_n_i        (dim_n_i),
    .dim_k_i        (dim_k_i),
    .weight_width_i (weight_width_i),
    .pop_i          (pop),
    .q_st_o         (q_st),
    .head_m_o       (head_m),
    .head_n_o       (head_n),
    .head_k_o       (head_k),
    .head_wb_o      (head_wb)
  );

  mtsp_back #(
    .W (DIM_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_st_i            (q_st),
    .head_m_i          (head_m),
    .head_n_i          (head_n),
    .head_k_i          (head_k),
    .head_wb_i         (head_wb),
    .pop_o             (pop),
    .budget_i          (budget_q),
    .step_i            (step_q),
    .done_o            (done_o),
    .shape_ok_o        (shape_ok_o),
    .tile_height_o     (tile_height_o),
    .tile_width_o      (tile_width_o),
    .row_tiles_o       (row_tiles_o),
    .col_tiles_o       (col_tiles_o),
    .last_row_height_o (last_row_height_o),
    .last_col_width_o  (last_col_width_o),
    .max_working_set_o (max_working_set_o),
    .is_tiled_o        (is_tiled_o),
    .fits_budget_o     (fits_budget_o)
  );

`ifndef SYNTH
  // A rejected shape carries a zero tile size, a zero working set and clear flags
  a_zero_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !shape_ok_o |-> tile_height_o == '0 && tile_width_o == '0 &&
      max_working_set_o == '0 && !fits_budget_o && !is_tiled_o)
    else $error("zero-dimension result carries nonzero fields");

  // An unlimited budget always fits
  a_unlimited_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && shape_ok_o && budget_q == '0 |-> fits_budget_o)
    else $error("unlimited budget reported as not fitting");

  // A valid shape always has a nonzero working set
  a_ws_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && shape_ok_o |-> max_working_set_o != '0)
    else $error("valid shape with zero working set");
`endif

endmodule
